>>> hdl/tde_pkg.sv
`default_nettype none

package tde_pkg;

  localparam int MAX_DELAY = 4096;
  localparam int ECHO_BITS = 8;
  localparam int ADDR_W    = $clog2(MAX_DELAY);
  localparam int DELAY_W   = 13;
  localparam int VEL_W     = 16;
  localparam int IDX_W     = 9;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;

  localparam logic [VEL_W-1:0]   VEL_ONE     = VEL_W'(32768);
  localparam logic [IDX_W-1:0]   IDX_CLEARED = '1;
  localparam logic [ECHO_BITS-1:0] ECHO_MAX  = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DELAY_LENGTH  = 2'd0,
    REG_ECHO_COUNT    = 2'd1,
    REG_PASS_INPUT    = 2'd2,
    REG_VELOCITY_STEP = 2'd3
  } cfg_reg_t;

  // Settings as the datapath sees them, with the derived length and total.
  typedef struct packed {
    logic [DELAY_W-1:0]   eff_length;
    logic [ECHO_BITS-1:0] total;
    logic                 pass_input;
    logic [VEL_W-1:0]     velocity_step;
  } cfg_t;

  typedef struct packed {
    logic             trig;
    logic [VEL_W-1:0] velocity;
    logic [IDX_W-1:0] index;
  } held_t;

endpackage

`default_nettype wire

>>> hdl/tde_ring_mem.sv
`default_nettype none

module tde_ring_mem
  import tde_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [ADDR_W-1:0]    waddr,
  input  wire logic [ECHO_BITS-1:0] wdata,
  input  wire logic                 re,
  input  wire logic [ADDR_W-1:0]    raddr,
  output logic      [ECHO_BITS-1:0] rdata
);

  logic [ECHO_BITS-1:0] mem [MAX_DELAY];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> hdl/tde_cfg.sv
`default_nettype none

module tde_cfg
  import tde_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  output cfg_t                      cfg
);

  logic [DELAY_W-1:0]   delay_length;
  logic [ECHO_BITS-1:0] echo_count;
  logic                 pass_input;
  logic [VEL_W-1:0]     velocity_step;
  logic [ECHO_BITS:0]   total_sum;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_length  <= DELAY_W'(1);
      echo_count    <= ECHO_BITS'(1);
      pass_input    <= 1'b0;
      velocity_step <= VEL_ONE;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_DELAY_LENGTH:  delay_length  <= cfg_data[DELAY_W-1:0];
        REG_ECHO_COUNT:    echo_count    <= cfg_data[ECHO_BITS-1:0];
        REG_PASS_INPUT:    pass_input    <= cfg_data[0];
        REG_VELOCITY_STEP: velocity_step <= cfg_data[VEL_W-1:0];
        default: ;
      endcase
    end
  end

  assign total_sum = {1'b0, echo_count} + (ECHO_BITS+1)'(pass_input);

  always_comb begin
    if (delay_length == '0) begin
      cfg.eff_length = DELAY_W'(1);
    end else if (delay_length > DELAY_W'(MAX_DELAY)) begin
      cfg.eff_length = DELAY_W'(MAX_DELAY);
    end else begin
      cfg.eff_length = delay_length;
    end
    cfg.total         = total_sum[ECHO_BITS] ? ECHO_MAX : total_sum[ECHO_BITS-1:0];
    cfg.pass_input    = pass_input;
    cfg.velocity_step = velocity_step;
  end

endmodule

`default_nettype wire

>>> hdl/tde_echo_calc.sv
`default_nettype none

module tde_echo_calc
  import tde_pkg::*;
(
  input  wire logic                 trig,
  input  wire logic [ECHO_BITS-1:0] slot,
  input  wire cfg_t                 cfg,
  input  wire held_t                held,
  output logic      [ECHO_BITS-1:0] slot_next,
  output held_t                     held_next
);

  logic [ECHO_BITS-1:0]       rem;
  logic [ECHO_BITS+VEL_W-1:0] vel_full;
  logic [VEL_W-1:0]           vel_sat;
  logic [IDX_W-1:0]           idx;

  assign rem      = slot - ECHO_BITS'(1);
  assign vel_full = (ECHO_BITS+VEL_W)'(rem) * (ECHO_BITS+VEL_W)'(cfg.velocity_step);
  assign vel_sat  = (vel_full > (ECHO_BITS+VEL_W)'(VEL_ONE)) ? VEL_ONE : vel_full[VEL_W-1:0];
  assign idx      = IDX_W'(cfg.total) - IDX_W'(1) - IDX_W'(rem);

  always_comb begin
    slot_next = slot;
    held_next = held;
    if (trig) begin
      slot_next = cfg.total;
      if (cfg.pass_input) begin
        held_next = '{trig: 1'b1, velocity: VEL_ONE, index: '0};
      end
    end else if (slot != '0) begin
      slot_next = rem;
      held_next = '{trig: 1'b1, velocity: vel_sat, index: idx};
    end else begin
      held_next.trig = 1'b0;
    end
  end

endmodule

`default_nettype wire

>>> hdl/trigger_echo_delay.sv
// Trigger echo delay.
// Input channel (in_valid/in_ready) takes one item per sample tick with the
// trigger and clear flags. Output channel (out_valid/out_ready) returns one
// item per input item: the held trigger, the Q1.15 velocity and the echo index.
// The echo counters live in a single-port-read, single-port-write memory of
// MAX_DELAY entries. The slot is read at the edge that accepts an item and,
// unless the item clears, written back at the edge where the result enters
// the output register, which then offers it. The block takes no new item
// until the write-back state for the last one has passed.
// The output register lets a new item be accepted while the last result still
// waits; if the receiver stalls, the second item holds in the write-back state
// and in_ready stays low until the output register is free.
// After reset, and after every item with clear set, the memory is zeroed at one
// entry per cycle over all MAX_DELAY (4096) entries, while in_ready is low. The
// result of a clear item is offered before the zeroing ends. Configuration writes (cfg_valid,
// cfg_index, cfg_data) are taken in any cycle and belong in idle periods only.
`default_nettype none

module trigger_echo_delay
  import tde_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 trigger,
  input  wire logic                 clear,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      trig_out,
  output logic      [VEL_W-1:0]     velocity,
  output logic signed [IDX_W-1:0]   echo_index
);

  typedef enum logic [1:0] {
    S_SWEEP,
    S_IDLE,
    S_WB
  } state_t;

  state_t               state;
  cfg_t                 cfg;
  held_t                held;
  held_t                held_next;
  logic [ADDR_W-1:0]    pos;
  logic [ADDR_W:0]      pos_inc;
  logic [ADDR_W-1:0]    pos_next;
  logic [ADDR_W-1:0]    sweep_addr;
  logic                 trig_q;
  logic                 clr_q;
  logic [ECHO_BITS-1:0] slot;
  logic [ECHO_BITS-1:0] slot_next;
  logic                 accept;
  logic                 wb_go;
  logic                 mem_we;
  logic [ADDR_W-1:0]    mem_waddr;
  logic [ECHO_BITS-1:0] mem_wdata;

  tde_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tde_ring_mem u_ring (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (accept),
    .raddr (pos),
    .rdata (slot)
  );

  tde_echo_calc u_calc (
    .trig      (trig_q),
    .slot      (slot),
    .cfg       (cfg),
    .held      (held),
    .slot_next (slot_next),
    .held_next (held_next)
  );

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign wb_go    = (state == S_WB) && (!out_valid || out_ready);

  assign pos_inc  = {1'b0, pos} + (ADDR_W+1)'(1);
  assign pos_next = ((ADDR_W+1 >= DELAY_W ? (ADDR_W+1)'(pos_inc) : pos_inc) >=
                     (ADDR_W+1)'(cfg.eff_length)) ? '0 : pos_inc[ADDR_W-1:0];

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pos;
    mem_wdata = slot_next;
    if (state == S_SWEEP) begin
      mem_we    = 1'b1;
      mem_waddr = sweep_addr;
      mem_wdata = '0;
    end else if (wb_go && !clr_q) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_SWEEP;
      sweep_addr <= '0;
      pos        <= '0;
      held       <= '0;
      out_valid  <= 1'b0;
    end else begin
      // A new result may replace the one accepted at this same edge.
      if (wb_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_SWEEP: begin
          sweep_addr <= sweep_addr + ADDR_W'(1);
          if (sweep_addr == ADDR_W'(MAX_DELAY - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            trig_q <= trigger;
            clr_q  <= clear;
            state  <= S_WB;
          end
        end
        S_WB: begin
          if (wb_go) begin
            if (clr_q) begin
              // A clear leaves the walk where it is and wipes every counter.
              held       <= '{trig: 1'b0, velocity: '0, index: IDX_CLEARED};
              trig_out   <= 1'b0;
              velocity   <= '0;
              echo_index <= $signed(IDX_CLEARED);
              sweep_addr <= '0;
              state      <= S_SWEEP;
            end else begin
              held       <= held_next;
              trig_out   <= held_next.trig;
              velocity   <= held_next.velocity;
              echo_index <= $signed(held_next.index);
              pos        <= pos_next;
              state      <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_sweep_writes_zero: assert property (@(posedge clk) disable iff (rst)
    (state == S_SWEEP) |-> (mem_we && mem_wdata == '0 && !in_ready))
    else $error("clearing pass does not zero the ring");

  a_accept_to_wb: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_WB))
    else $error("accepted item did not reach write-back");

  a_wb_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_WB && !wb_go) |=> (state == S_WB && $stable(slot)))
    else $error("stalled write-back lost its read data");

  a_vel_sat: assert property (@(posedge clk) disable iff (rst)
    held.velocity <= VEL_ONE)
    else $error("held velocity above 1.0");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    wb_go && !clr_q |=> (DELAY_W'(pos) < cfg.eff_length))
    else $error("ring position beyond delay length");
`endif

endmodule

`default_nettype wire

>>> tb/sv/trigger_echo_delay_test.sv
`timescale 1ns / 100ps

module trigger_echo_delay_test;
  import tde_pkg::*;

  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_STALL = 400;

  logic clk;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic trigger = 1'b0;
  logic clear = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic trig_out;
  logic [VEL_W-1:0] velocity;
  logic signed [IDX_W-1:0] echo_index;

  // Echo predictor state and its copy of the registers.
  logic [ECHO_BITS-1:0] echo_slots [MAX_DELAY];
  int unsigned slot_pos;
  held_t held_now;
  logic [DELAY_W-1:0] set_delay;
  logic [ECHO_BITS-1:0] set_count;
  logic set_pass;
  logic [VEL_W-1:0] set_step;

  held_t pending_results [$];

  bit send_gaps = 1'b1;
  bit recv_gaps = 1'b1;
  int stall_request = 0;
  int error_count = 0;
  int items_sent = 0;
  int clears_sent = 0;
  int results_seen = 0;
  int echoes_seen = 0;
  int reg_writes = 0;
  int settings_used = 0;
  int random_items = 0;

  trigger_echo_delay u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .trigger(trigger),
    .clear(clear),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .trig_out(trig_out),
    .velocity(velocity),
    .echo_index(echo_index)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("Timed out at %0t with %0d results outstanding.", $time,
             pending_results.size());
    $display("== FAIL ==");
    $finish;
  end

  function automatic int unsigned ring_len();
    if (set_delay == 0) return 1;
    if (set_delay > MAX_DELAY) return MAX_DELAY;
    return set_delay;
  endfunction

  function automatic int unsigned event_total();
    int unsigned t;
    t = int'(set_count) + int'(set_pass);
    if (t > ECHO_MAX) t = ECHO_MAX;
    return t;
  endfunction

  function automatic void reset_echo_state();
    foreach (echo_slots[i]) echo_slots[i] = '0;
    slot_pos = 0;
    held_now = '0;
    set_delay = DELAY_W'(1);
    set_count = ECHO_BITS'(1);
    set_pass = 1'b0;
    set_step = VEL_ONE;
  endfunction

  // Works out the held outputs after one sample tick.
  function automatic held_t advance_tick(input logic trig, input logic clr);
    int unsigned pos;
    int unsigned rem;
    int unsigned vel;
    if (clr) begin
      foreach (echo_slots[i]) echo_slots[i] = '0;
      held_now = '{trig: 1'b0, velocity: '0, index: IDX_CLEARED};
    end else begin
      pos = slot_pos;
      if (trig) begin
        echo_slots[pos] = ECHO_BITS'(event_total());
        if (set_pass) held_now = '{trig: 1'b1, velocity: VEL_ONE, index: '0};
      end else if (echo_slots[pos] != 0) begin
        rem = int'(echo_slots[pos]) - 1;
        vel = rem * set_step;
        echo_slots[pos] = ECHO_BITS'(rem);
        held_now.trig = 1'b1;
        held_now.velocity = (vel > VEL_ONE) ? VEL_ONE : VEL_W'(vel);
        // Wraps within the index width when the total shrank meanwhile.
        held_now.index = IDX_W'(event_total() - 1 - rem);
      end else begin
        held_now.trig = 1'b0;
      end
      pos++;
      if (pos >= ring_len()) pos = 0;
      slot_pos = pos;
    end
    return held_now;
  endfunction

  task automatic send_tick(input logic trig, input logic clr);
    if (send_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid <= 1'b1;
    trigger <= trig;
    clear <= clr;
    do @(posedge clk); while (!(in_valid && in_ready));
    pending_results.push_back(advance_tick(trig, clr));
    items_sent++;
    if (clr) clears_sent++;
  endtask

  // Leaves the block with no result owed and any clearing pass finished.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t which, input logic [CFG_W-1:0] value);
    if (!cfg_valid) cfg_valid <= 1'b1;
    cfg_index <= which;
    cfg_data <= value;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    case (which)
      REG_DELAY_LENGTH:  set_delay = value[DELAY_W-1:0];
      REG_ECHO_COUNT:    set_count = value[ECHO_BITS-1:0];
      REG_PASS_INPUT:    set_pass = value[0];
      REG_VELOCITY_STEP: set_step = value[VEL_W-1:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic apply_settings(input logic [DELAY_W-1:0] dly, input logic [ECHO_BITS-1:0] cnt,
                                input logic pass, input logic [VEL_W-1:0] step);
    wait_idle();
    write_reg(REG_DELAY_LENGTH, CFG_W'(dly));
    write_reg(REG_ECHO_COUNT, CFG_W'(cnt));
    write_reg(REG_PASS_INPUT, CFG_W'(pass));
    write_reg(REG_VELOCITY_STEP, step);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic pick_random_settings();
    logic [DELAY_W-1:0] dly;
    logic [ECHO_BITS-1:0] cnt;
    logic pass;
    logic [VEL_W-1:0] step;
    case ($urandom_range(0, 9))
      0: dly = '0;
      1: dly = '1;
      2: dly = DELAY_W'(MAX_DELAY);
      3: dly = DELAY_W'($urandom);
      default: dly = DELAY_W'($urandom_range(1, 12));
    endcase
    case ($urandom_range(0, 7))
      0: cnt = '0;
      1: cnt = '1;
      2: cnt = ECHO_BITS'(254);
      3: cnt = ECHO_BITS'($urandom);
      default: cnt = ECHO_BITS'($urandom_range(1, 8));
    endcase
    pass = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 7))
      0: step = '0;
      1: step = '1;
      2: step = VEL_W'($urandom);
      default: step = (cnt == 0) ? VEL_ONE : VEL_W'((32768 + cnt / 2) / cnt);
    endcase
    apply_settings(dly, cnt, pass, step);
  endtask

  // Receiver: random stalls, plus one long hold when a test asks for it.
  initial begin
    @(posedge clk);
    forever begin
      if (stall_request > 0) begin
        out_ready <= 1'b0;
        repeat (stall_request) @(posedge clk);
        stall_request = 0;
      end else if (recv_gaps && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  task automatic report_field(input string name, input int want, input int got);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    error_count++;
  endtask

  initial begin
    held_t want;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        results_seen++;
        if (trig_out && echo_index > 0) echoes_seen++;
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected item, expected none, got trig_out=%0b velocity=%0d index=%0d",
                   $time, trig_out, velocity, echo_index);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          if (want.trig !== trig_out) report_field("trig_out", want.trig, trig_out);
          if (want.velocity !== velocity) report_field("velocity", want.velocity, velocity);
          if (want.index !== echo_index)
            report_field("echo_index", $signed(want.index), echo_index);
        end
      end
    end
  end

  task automatic test_basic_events();
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b0);
    apply_settings(DELAY_W'(3), ECHO_BITS'(2), 1'b1, VEL_W'(16384));
    send_tick(1'b1, 1'b0);
    repeat (6) send_tick(1'b0, 1'b0);
  endtask

  task automatic test_clear();
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
  endtask

  // Zero count with and without pass-through, then a total that saturates.
  task automatic test_total_limits();
    apply_settings(DELAY_W'(1), '0, 1'b0, '0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    apply_settings(DELAY_W'(1), '0, 1'b1, '1);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    apply_settings(DELAY_W'(1), '1, 1'b1, '1);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
  endtask

  task automatic test_delay_limits();
    apply_settings('0, ECHO_BITS'(1), 1'b0, VEL_ONE);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    apply_settings('1, ECHO_BITS'(1), 1'b1, VEL_ONE);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    // Shrinking the ring while the walk sits beyond its new end.
    apply_settings(DELAY_W'(2), ECHO_BITS'(1), 1'b0, VEL_ONE);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b0);
  endtask

  // Echoes left over from a larger total come out with wrapped indexes.
  task automatic test_pending_reg_change();
    apply_settings(DELAY_W'(1), ECHO_BITS'(6), 1'b0, VEL_W'(5461));
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    apply_settings(DELAY_W'(1), ECHO_BITS'(1), 1'b0, VEL_ONE);
    repeat (3) send_tick(1'b0, 1'b0);
  endtask

  task automatic test_long_train();
    apply_settings(DELAY_W'(1), ECHO_BITS'(254), 1'b1, VEL_W'(129));
    send_tick(1'b1, 1'b0);
    repeat (258) send_tick($urandom_range(0, 63) == 0, 1'b0);
  endtask

  task automatic test_backpressure();
    apply_settings(DELAY_W'(4), ECHO_BITS'(3), 1'b1, VEL_W'(10923));
    send_gaps = 1'b0;
    stall_request = LONG_STALL;
    repeat (60) send_tick($urandom_range(0, 2) == 0, 1'b0);
    send_gaps = 1'b1;
  endtask

  task automatic test_random_phases();
    int n;
    while (random_items < 1050) begin
      pick_random_settings();
      n = $urandom_range(20, 80);
      repeat (n) begin
        send_tick($urandom_range(0, 3) == 0, $urandom_range(0, 199) == 0);
        random_items++;
      end
    end
  endtask

  task automatic test_full_rate();
    send_gaps = 1'b0;
    recv_gaps = 1'b0;
    apply_settings(DELAY_W'($urandom_range(1, 6)), ECHO_BITS'($urandom_range(2, 5)), 1'b1,
                   VEL_W'(8192));
    repeat (150) send_tick($urandom_range(0, 4) == 0, 1'b0);
  endtask

  initial begin
    reset_echo_state();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    wait_idle();
    test_basic_events();
    test_clear();
    test_total_limits();
    test_delay_limits();
    test_pending_reg_change();
    test_long_train();
    test_backpressure();
    test_random_phases();
    test_full_rate();
    wait_idle();
    $display("Run covered %0d items and %0d results, %0d of them echoes, with %0d clears.",
             items_sent, results_seen, echoes_seen, clears_sent);
    $display("Registers took %0d writes over %0d settings, with one long receiver stall.",
             reg_writes, settings_used);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches found.", error_count);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
